FILE: rtl/core/wbps_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search package
// Shared widths, types, register codes and a helper function.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Deepest pattern the window can hold.
  localparam int MAX_PATTERN = 16;
  // Pattern bytes carried by the two pattern registers.
  localparam int PAT_BYTES   = 16;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 5;
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W      = 63;
  localparam int OCC_W       = 16;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 6;

  typedef logic [MAX_PATTERN-1:0][7:0] win_t;
  typedef logic [PAT_BYTES-1:0][7:0]   pat_t;

  // Register index, taken from paddr[5:3].
  typedef enum logic [2:0] {
    REG_PATTERN_LOW   = 3'd0,
    REG_PATTERN_HIGH  = 3'd1,
    REG_WILDCARD_MASK = 3'd2,
    REG_PATTERN_LEN   = 3'd3,
    REG_OCCURRENCE    = 3'd4,
    REG_START_ADDR    = 3'd5
  } reg_idx_t;

  // Length register value mapped onto the usable range.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    len = raw;
    if (len == '0) len = LEN_W'(1);
    if (len > LEN_W'(PAT_BYTES)) len = LEN_W'(PAT_BYTES);
    if (len > LEN_W'(MAX_PATTERN)) len = LEN_W'(MAX_PATTERN);
    return len;
  endfunction

endpackage

FILE: rtl/core/wbps_if.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search channels
// Valid/ready channels for incoming bytes and outgoing search results.
// ----------------------------------------------------------------------------
interface wbps_in_if import wbps_pkg::*; ();
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
  logic valid;
  logic ready;
  logic found;
  logic [ADDR_W-1:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink (input valid, input found, input match_address, output ready);
endinterface

FILE: rtl/core/wildcard_byte_pattern_search_unit.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search unit
// Finds the Nth, possibly overlapping, match of a wildcard byte pattern in
// a stream of bytes and reports its start address, or not found at range end.
// ----------------------------------------------------------------------------
// A result is registered and is on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle; the window compare and the address add sit
//   between the window register and the result register.
// A byte is taken whenever the result register is empty or being drained.
// Reset (rst, synchronous) loads register defaults and starts a fresh range.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_unit import wbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  wbps_in_if.sink               byte_ch,
  wbps_out_if.source            result_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers.
  logic [63:0]       pattern_low;
  logic [63:0]       pattern_high;
  logic [15:0]       wildcard_mask;
  logic [LEN_W-1:0]  pattern_length;
  logic [OCC_W-1:0]  occurrence_number;
  logic [ADDR_W-1:0] start_address;

  // Search state.
  win_t              byte_window;
  logic [FILL_W-1:0] window_fill;
  logic [ADDR_W-1:0] byte_position;
  logic [OCC_W-1:0]  matches_left;
  logic              search_done;

  // Result register.
  logic              out_valid;
  logic              out_found;
  logic [ADDR_W-1:0] out_address;

  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic              in_acc;
  logic [LEN_W-1:0]  len;
  win_t              byte_window_next;
  logic [FILL_W-1:0] window_fill_next;
  logic [OCC_W-1:0]  matches_cur;
  logic              hit;
  logic              report;
  logic              give_result;

  // APB register port; writes complete in the access phase.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low       <= '0;
      pattern_high      <= '0;
      wildcard_mask     <= '0;
      pattern_length    <= LEN_W'(1);
      occurrence_number <= OCC_W'(1);
      start_address     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PATTERN_LOW:   pattern_low       <= pwdata;
        REG_PATTERN_HIGH:  pattern_high      <= pwdata;
        REG_WILDCARD_MASK: wildcard_mask     <= pwdata[15:0];
        REG_PATTERN_LEN:   pattern_length    <= pwdata[LEN_W-1:0];
        REG_OCCURRENCE:    occurrence_number <= pwdata[OCC_W-1:0];
        REG_START_ADDR:    start_address     <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_idx)
      REG_PATTERN_LOW:   prdata = pattern_low;
      REG_PATTERN_HIGH:  prdata = pattern_high;
      REG_WILDCARD_MASK: prdata = APB_DATA_W'(wildcard_mask);
      REG_PATTERN_LEN:   prdata = APB_DATA_W'(pattern_length);
      REG_OCCURRENCE:    prdata = APB_DATA_W'(occurrence_number);
      REG_START_ADDR:    prdata = APB_DATA_W'(start_address);
      default:           prdata = '0;
    endcase
  end

  // A byte is taken while the result register is free or being emptied.
  assign byte_ch.ready = !out_valid || result_ch.ready;
  assign in_acc        = byte_ch.valid && byte_ch.ready;

  // Window after the incoming byte is shifted in, and the fill that goes with it.
  always_comb begin
    byte_window_next[0] = byte_ch.data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      byte_window_next[k] = byte_window[k-1];
    end
    if (window_fill < FILL_W'(MAX_PATTERN)) begin
      window_fill_next = window_fill + FILL_W'(1);
    end else begin
      window_fill_next = window_fill;
    end
  end

  assign len = eff_len(pattern_length);

  wbps_match u_match (
    .window        (byte_window_next),
    .pattern       ({pattern_high, pattern_low}),
    .wildcard_mask (wildcard_mask),
    .len           (len),
    .hit           (hit)
  );

  // The match count reloads on the first byte of every range.
  always_comb begin
    if (byte_position == '0) begin
      matches_cur = (occurrence_number == '0) ? OCC_W'(1) : occurrence_number;
    end else begin
      matches_cur = matches_left;
    end
  end

  assign report = !search_done && hit && (FILL_W'(len) <= window_fill_next) &&
                  (matches_cur <= OCC_W'(1));
  assign give_result = !search_done && (report || byte_ch.last_byte);

  // Search state update per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill   <= '0;
      byte_position <= '0;
      matches_left  <= '0;
      search_done   <= 1'b0;
    end else if (in_acc) begin
      matches_left <= matches_cur;
      if (!search_done) begin
        window_fill <= window_fill_next;
        if (report) begin
          search_done <= 1'b1;
        end else if (hit && (FILL_W'(len) <= window_fill_next)) begin
          matches_left <= matches_cur - OCC_W'(1);
        end
      end
      if (byte_ch.last_byte) begin
        window_fill   <= '0;
        byte_position <= '0;
        search_done   <= 1'b0;
      end else begin
        byte_position <= byte_position + ADDR_W'(1);
      end
    end
  end

  // Window bytes are only read once filled, so they need no clearing.
  always_ff @(posedge clk) begin
    if (in_acc && !search_done) begin
      byte_window <= byte_window_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && give_result) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && give_result) begin
      out_found <= report;
      if (report) begin
        out_address <= start_address + byte_position - ADDR_W'(len - LEN_W'(1));
      end else begin
        out_address <= '0;
      end
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.found         = out_found;
  assign result_ch.match_address = out_address;

  // A not-found beat always carries a zero address.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_address == '0)
    else $error("not-found result with nonzero address");

  // Bytes after a report produce no further results.
  a_quiet_after_report: assert property (@(posedge clk) disable iff (rst)
    in_acc && search_done |=> !out_valid)
    else $error("result produced after the match was reported");

  // The final byte of a range restarts the search.
  a_range_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && byte_ch.last_byte |=> byte_position == '0 && !search_done &&
      window_fill == '0)
    else $error("range end did not restart the search");

  // The window fill saturates at the window depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill <= FILL_W'(MAX_PATTERN))
    else $error("window fill beyond window depth");

  // A report leaves the search marked done unless the range ended.
  a_done_after_found: assert property (@(posedge clk) disable iff (rst)
    in_acc && report && !byte_ch.last_byte |=> search_done)
    else $error("search not marked done after a report");

endmodule

FILE: rtl/core/wbps_match.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search window compare
// Compares the newest bytes of the window with the pattern, skipping
// wildcard positions, in one level of parallel byte compares.
// ----------------------------------------------------------------------------
module wbps_match import wbps_pkg::*; (
  input  win_t             window,
  input  pat_t             pattern,
  input  logic [15:0]      wildcard_mask,
  input  logic [LEN_W-1:0] len,
  output logic             hit
);

  logic [MAX_PATTERN-1:0] byte_ok;

  // Pattern byte k lines up with window entry len-1-k (entry 0 is newest).
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      logic [LEN_W-1:0] pos;
      pos = len - LEN_W'(1) - LEN_W'(k);
      if (LEN_W'(k) >= len) begin
        byte_ok[k] = 1'b1;
      end else if (k < PAT_BYTES && wildcard_mask[k]) begin
        byte_ok[k] = 1'b1;
      end else if (k < PAT_BYTES) begin
        byte_ok[k] = (window[pos[IDX_W-1:0]] == pattern[k]);
      end else begin
        byte_ok[k] = 1'b0;
      end
    end
  end

  assign hit = &byte_ok;

endmodule
